// ===== src/ggnh_pkg.sv =====
// Shared package for the greedy geographic next-hop core.
// Holds field widths, default parameters, status codes and controller/datapath structs.
// No dependencies.
package ggnh_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_COORD_WIDTH = 20;
    localparam int ID_WIDTH        = 32;
    localparam int STATUS_WIDTH    = 3;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_ID   = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_GREEDY   = 3'd4;
    localparam logic [STATUS_WIDTH-1:0] ST_FALLBACK = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load;    // input transfer, latch the item
        logic issue;   // a scan slot is presented this cycle
        logic self;    // the slot is the own-position slot of a query
        logic finish;  // produce the result (and table write for updates)
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic busy;      // scan pipeline still holds slots
        logic out_free;  // output register can take a result this cycle
        logic insert;    // the pending update claims a new table slot
    } t_dp_status;

endpackage

// ===== src/ggnh_if.sv =====
// Valid/ready channel interfaces for the next-hop core: request items and results.
// Depends on ggnh_pkg.
interface ggnh_item_if #(
    parameter int COORD_WIDTH = ggnh_pkg::DEF_COORD_WIDTH
);
    import ggnh_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [ID_WIDTH-1:0]           node_id;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;

    modport source (output valid, cmd, node_id, pos_x, pos_y, target_x, target_y,
                    input ready);
    modport sink   (input valid, cmd, node_id, pos_x, pos_y, target_x, target_y,
                    output ready);
endinterface

interface ggnh_result_if;
    import ggnh_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ID_WIDTH-1:0]     next_hop;
    logic [STATUS_WIDTH-1:0] status;

    modport source (output valid, next_hop, status, input ready);
    modport sink   (input valid, next_hop, status, output ready);
endinterface

// ===== src/ggnh_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module ggnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/ggnh_ctrl.sv =====
// Controller for the next-hop core: input handshake, table scan sequencing, fill count.
// Depends on ggnh_pkg.
module ggnh_ctrl #(
    parameter int TABLE_DEPTH = ggnh_pkg::DEF_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CNTW        = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_query,
    input  logic                   i_in_id_zero,
    output logic                   o_in_ready,
    output ggnh_pkg::t_ctl_cmd     o_cmd,
    output logic [AW-1:0]          o_addr,
    output logic [CNTW-1:0]        o_count,
    input  ggnh_pkg::t_dp_status   i_status
);
    import ggnh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} t_state;

    t_state          r_state;
    logic            r_ready;
    logic            r_issue;
    logic            r_self;
    logic [AW-1:0]   r_addr;
    logic [CNTW-1:0] r_count;
    logic            w_accept;
    logic            w_last;

    assign w_accept = i_in_valid && r_ready;
    // valid entries always form a prefix of the table, so the fill count bounds the scan
    assign w_last   = r_self ? (r_count == '0) : ((CNTW'(r_addr) + CNTW'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
            r_issue <= 1'b0;
            r_self  <= 1'b0;
            r_addr  <= '0;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ready <= 1'b0;
                        if ((i_in_query == CMD_UPDATE) && (i_in_id_zero || r_count == '0)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                            r_issue <= 1'b1;
                            r_self  <= i_in_query;
                            r_addr  <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_issue <= 1'b0;
                        r_self  <= 1'b0;
                        r_state <= S_DRAIN;
                    end else if (r_self) begin
                        r_self <= 1'b0;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!i_status.busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                        if (i_status.insert) begin
                            r_count <= r_count + CNTW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready    = r_ready;
    assign o_addr        = r_addr;
    assign o_count       = r_count;
    assign o_cmd.load    = w_accept;
    assign o_cmd.issue   = r_issue;
    assign o_cmd.self    = r_self;
    assign o_cmd.finish  = (r_state == S_FINISH) && i_status.out_free;
endmodule

// ===== src/ggnh_dp.sv =====
// Datapath for the next-hop core: neighbor table RAM, distance pipeline,
// greedy/fallback minimum tracking, id match, and the result register.
// Depends on ggnh_pkg and ggnh_ram.
module ggnh_dp #(
    parameter int TABLE_DEPTH = ggnh_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_WIDTH = ggnh_pkg::DEF_COORD_WIDTH,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int CNTW        = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ggnh_pkg::t_ctl_cmd                 i_cmd,
    input  logic [AW-1:0]                      i_addr,
    input  logic [CNTW-1:0]                    i_count,
    input  logic                               i_in_cmd,
    input  logic [ggnh_pkg::ID_WIDTH-1:0]      i_in_node_id,
    input  logic signed [COORD_WIDTH-1:0]      i_in_pos_x,
    input  logic signed [COORD_WIDTH-1:0]      i_in_pos_y,
    input  logic signed [COORD_WIDTH-1:0]      i_in_target_x,
    input  logic signed [COORD_WIDTH-1:0]      i_in_target_y,
    output ggnh_pkg::t_dp_status               o_status,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ggnh_pkg::ID_WIDTH-1:0]      o_out_next_hop,
    output logic [ggnh_pkg::STATUS_WIDTH-1:0]  o_out_status
);
    import ggnh_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int MW  = CW + 1;        // magnitude of a coordinate difference
    localparam int SQW = 2 * MW;
    localparam int DW  = SQW + 1;       // squared distance
    localparam int RW  = ID_WIDTH + 2 * CW;

    // latched item
    logic                 r_query;
    logic [ID_WIDTH-1:0]  r_id;
    logic signed [CW-1:0] r_px, r_py, r_tx, r_ty;

    // table
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [RW-1:0] w_rdata;

    // stage 1: RAM read data
    logic          r_p1_valid, r_p1_self;
    logic [AW-1:0] r_p1_addr;
    logic [ID_WIDTH-1:0]  w_rd_id;
    logic signed [CW-1:0] w_pt_x, w_pt_y;
    logic signed [CW:0]   w_dxn, w_dyn, w_dxf, w_dyf;

    // stage 2: magnitudes
    logic                r_p2_valid, r_p2_self;
    logic [ID_WIDTH-1:0] r_p2_id;
    logic [MW-1:0]       r_p2_axn, r_p2_ayn, r_p2_axf, r_p2_ayf;

    // stage 3: squares
    logic                r_p3_valid, r_p3_self;
    logic [ID_WIDTH-1:0] r_p3_id;
    logic [SQW-1:0]      r_p3_sxn, r_p3_syn, r_p3_sxf, r_p3_syf;

    // stage 4: distances
    logic                r_p4_valid, r_p4_self;
    logic [ID_WIDTH-1:0] r_p4_id;
    logic [DW-1:0]       r_p4_dn, r_p4_df;

    // accumulators
    logic [DW-1:0]       r_dself, r_g_best, r_f_best;
    logic [ID_WIDTH-1:0] r_g_id, r_f_id;
    logic                r_g_found, r_f_found;
    logic                r_hit;
    logic [AW-1:0]       r_hit_addr;
    logic                w_g_take, w_f_take;

    // result register
    logic                    r_o_valid;
    logic [ID_WIDTH-1:0]     r_o_hop;
    logic [STATUS_WIDTH-1:0] r_o_status;
    logic                    w_id_zero, w_room;

    assign w_id_zero = (r_id == '0);
    assign w_room    = (i_count < CNTW'(TABLE_DEPTH));

    assign w_we    = i_cmd.finish && !r_query && !w_id_zero && (r_hit || w_room);
    assign w_waddr = r_hit ? r_hit_addr : i_count[AW-1:0];

    ggnh_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_id, r_px, r_py}),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_query <= i_in_cmd;
            r_id    <= i_in_node_id;
            r_px    <= i_in_pos_x;
            r_py    <= i_in_pos_y;
            r_tx    <= i_in_target_x;
            r_ty    <= i_in_target_y;
        end
    end

    // stage 1 logic: the own-position slot reuses the pipe, giving dist(own, target)
    assign w_rd_id = w_rdata[RW-1 -: ID_WIDTH];
    assign w_pt_x  = r_p1_self ? r_px : $signed(w_rdata[2*CW-1 -: CW]);
    assign w_pt_y  = r_p1_self ? r_py : $signed(w_rdata[CW-1:0]);
    assign w_dxn   = {w_pt_x[CW-1], w_pt_x} - {r_tx[CW-1], r_tx};
    assign w_dyn   = {w_pt_y[CW-1], w_pt_y} - {r_ty[CW-1], r_ty};
    assign w_dxf   = {w_pt_x[CW-1], w_pt_x} - {r_px[CW-1], r_px};
    assign w_dyf   = {w_pt_y[CW-1], w_pt_y} - {r_py[CW-1], r_py};

    // tie-break toward the lowest id
    assign w_g_take = (r_p4_dn < r_dself) &&
                      (!r_g_found || (r_p4_dn < r_g_best) ||
                       ((r_p4_dn == r_g_best) && (r_p4_id < r_g_id)));
    assign w_f_take = !r_f_found || (r_p4_df < r_f_best) ||
                      ((r_p4_df == r_f_best) && (r_p4_id < r_f_id));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_g_found  <= 1'b0;
            r_f_found  <= 1'b0;
            r_hit      <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.issue;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
            if (i_cmd.load) begin
                r_g_found <= 1'b0;
                r_f_found <= 1'b0;
                r_hit     <= 1'b0;
            end else begin
                if (r_p1_valid && !r_p1_self && !r_hit && (w_rd_id == r_id)) begin
                    r_hit <= 1'b1;
                end
                if (r_p4_valid && !r_p4_self) begin
                    if (w_g_take) begin
                        r_g_found <= 1'b1;
                    end
                    if (w_f_take) begin
                        r_f_found <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_self <= i_cmd.self;
        r_p1_addr <= i_addr;
        if (r_p1_valid && !r_p1_self && !r_hit) begin
            r_hit_addr <= r_p1_addr;
        end

        r_p2_self <= r_p1_self;
        r_p2_id   <= w_rd_id;
        r_p2_axn  <= w_dxn[CW] ? $unsigned(-w_dxn) : $unsigned(w_dxn);
        r_p2_ayn  <= w_dyn[CW] ? $unsigned(-w_dyn) : $unsigned(w_dyn);
        r_p2_axf  <= w_dxf[CW] ? $unsigned(-w_dxf) : $unsigned(w_dxf);
        r_p2_ayf  <= w_dyf[CW] ? $unsigned(-w_dyf) : $unsigned(w_dyf);

        r_p3_self <= r_p2_self;
        r_p3_id   <= r_p2_id;
        r_p3_sxn  <= r_p2_axn * r_p2_axn;
        r_p3_syn  <= r_p2_ayn * r_p2_ayn;
        r_p3_sxf  <= r_p2_axf * r_p2_axf;
        r_p3_syf  <= r_p2_ayf * r_p2_ayf;

        r_p4_self <= r_p3_self;
        r_p4_id   <= r_p3_id;
        r_p4_dn   <= DW'(r_p3_sxn) + DW'(r_p3_syn);
        r_p4_df   <= DW'(r_p3_sxf) + DW'(r_p3_syf);

        if (r_p4_valid) begin
            if (r_p4_self) begin
                r_dself <= r_p4_dn;
            end else begin
                if (w_g_take) begin
                    r_g_best <= r_p4_dn;
                    r_g_id   <= r_p4_id;
                end
                if (w_f_take) begin
                    r_f_best <= r_p4_df;
                    r_f_id   <= r_p4_id;
                end
            end
        end
    end

    // result register, refilled in the same cycle it is drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_query) begin
                if (r_g_found) begin
                    r_o_hop    <= r_g_id;
                    r_o_status <= ST_GREEDY;
                end else begin
                    r_o_hop    <= r_f_found ? r_f_id : '0;
                    r_o_status <= ST_FALLBACK;
                end
            end else begin
                r_o_hop <= '0;
                if (w_id_zero) begin
                    r_o_status <= ST_BAD_ID;
                end else if (r_hit) begin
                    r_o_status <= ST_UPDATED;
                end else if (w_room) begin
                    r_o_status <= ST_INSERTED;
                end else begin
                    r_o_status <= ST_FULL;
                end
            end
        end
    end

    assign o_status.busy     = r_p1_valid || r_p2_valid || r_p3_valid || r_p4_valid;
    assign o_status.out_free = !r_o_valid || i_out_ready;
    assign o_status.insert   = !r_query && !w_id_zero && !r_hit && w_room;

    assign o_out_valid    = r_o_valid;
    assign o_out_next_hop = r_o_hop;
    assign o_out_status   = r_o_status;
endmodule

// ===== src/greedy_geo_next_hop_core.sv =====
// Channel   Dir  Payload                                             Transfer
// i_in      in   cmd, node_id, pos_x, pos_y, target_x, target_y      valid & ready
// o_out     out  next_hop, status                                    valid & ready
//
// An update scans the valid table prefix for the id, then writes; for id zero or an
// empty table it skips the scan. A query scans the own-position slot plus the stored
// entries through a 4-stage distance pipeline. One table RAM read port sets the scan pace.
// Reset (synchronous, active low) empties the table at once through the fill count.
// A new item is taken while a result still waits; the finished one holds until o_out drains.
//
// Top level of the next-hop core; depends on ggnh_pkg, ggnh_if, ggnh_ctrl, ggnh_dp.
module greedy_geo_next_hop_core #(
    parameter int TABLE_DEPTH = ggnh_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_WIDTH = ggnh_pkg::DEF_COORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ggnh_item_if.sink   i_in,
    ggnh_result_if.source o_out
);
    import ggnh_pkg::*;

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    t_ctl_cmd        w_cmd;
    t_dp_status      w_status;
    logic [AW-1:0]   w_addr;
    logic [CNTW-1:0] w_count;
    logic            w_in_ready;

    ggnh_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CNTW        (CNTW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_query   (i_in.cmd),
        .i_in_id_zero (i_in.node_id == '0),
        .o_in_ready   (w_in_ready),
        .o_cmd        (w_cmd),
        .o_addr       (w_addr),
        .o_count      (w_count),
        .i_status     (w_status)
    );

    ggnh_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH),
        .AW          (AW),
        .CNTW        (CNTW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_addr         (w_addr),
        .i_count        (w_count),
        .i_in_cmd       (i_in.cmd),
        .i_in_node_id   (i_in.node_id),
        .i_in_pos_x     (i_in.pos_x),
        .i_in_pos_y     (i_in.pos_y),
        .i_in_target_x  (i_in.target_x),
        .i_in_target_y  (i_in.target_y),
        .o_status       (w_status),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_next_hop (o_out.next_hop),
        .o_out_status   (o_out.status)
    );

    assign i_in.ready = w_in_ready;
endmodule
